// ===== rtl/core/i2p_pkg.sv =====
// ----------------------------------------------------------------------------
// i2p_pkg
// Shared types, constants and the control store of the infix to postfix
// converter: token codes, stack entry layout and the microprogram.
// ----------------------------------------------------------------------------
package i2p_pkg;

	// Sizes
	localparam int STACK_DEPTH = 32;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int ID_W        = 16;
	localparam int PREC_W      = 4;
	localparam int UPC_W       = 5;

	// Incoming token codes
	typedef enum logic [2:0] {
		TOK_OPERAND = 3'd0,
		TOK_FUNC    = 3'd1,
		TOK_OPER    = 3'd2,
		TOK_LPAR    = 3'd3,
		TOK_RPAR    = 3'd4,
		TOK_END     = 3'd5
	} tok_op_t;

	// Kinds held on the stack and sent out
	typedef enum logic [1:0] {
		K_OPERAND = 2'd0,
		K_FUNC    = 2'd1,
		K_OPER    = 2'd2,
		K_LPAR    = 2'd3
	} kind_t;

	// Error codes on the result channel
	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_RPAR     = 2'd1,
		ERR_LPAR     = 2'd2,
		ERR_OVERFLOW = 2'd3
	} err_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [PREC_W-1:0] prec;
		kind_t             kind;
	} stk_entry_t;

	// Datapath actions of one microstep
	typedef enum logic [2:0] {
		ACT_IDLE,
		ACT_READ,
		ACT_NOP,
		ACT_EMIT_IN,
		ACT_PUSH,
		ACT_POP_EMIT,
		ACT_POP_DROP,
		ACT_ERR_RPAR
	} uact_t;

	// Jump conditions; the step falls through when the condition is false
	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_EMPTY,
		COND_NO_POP,
		COND_NOT_OPER,
		COND_NOT_LPAR,
		COND_NOT_FUNC,
		COND_DONE
	} ucond_t;

	typedef logic [UPC_W-1:0] upc_t;

	typedef struct packed {
		uact_t  act;
		ucond_t cond;
		upc_t   target;
	} ucw_t;

	// Control store addresses
	localparam upc_t UPC_IDLE  = UPC_W'(0);
	localparam upc_t UPC_OPND  = UPC_W'(1);
	localparam upc_t UPC_O0    = UPC_W'(2);
	localparam upc_t UPC_O1    = UPC_W'(3);
	localparam upc_t UPC_O2    = UPC_W'(4);
	localparam upc_t UPC_PUSH  = UPC_W'(5);
	localparam upc_t UPC_R0    = UPC_W'(6);
	localparam upc_t UPC_R1    = UPC_W'(7);
	localparam upc_t UPC_R2    = UPC_W'(8);
	localparam upc_t UPC_R3    = UPC_W'(9);
	localparam upc_t UPC_R4    = UPC_W'(10);
	localparam upc_t UPC_R5    = UPC_W'(11);
	localparam upc_t UPC_R6    = UPC_W'(12);
	localparam upc_t UPC_R7    = UPC_W'(13);
	localparam upc_t UPC_RERR  = UPC_W'(14);
	localparam upc_t UPC_E0    = UPC_W'(15);
	localparam upc_t UPC_E1    = UPC_W'(16);
	localparam upc_t UPC_DONE  = UPC_W'(17);

	// Microprogram: one control word per step
	function automatic ucw_t ucode(input upc_t upc);
		case (upc)
			UPC_IDLE: return '{ACT_IDLE,     COND_NEVER,    UPC_IDLE};
			// operand: send straight out
			UPC_OPND: return '{ACT_EMIT_IN,  COND_ALWAYS,   UPC_DONE};
			// operator: pop while the top binds tighter, then push
			UPC_O0:   return '{ACT_READ,     COND_EMPTY,    UPC_PUSH};
			UPC_O1:   return '{ACT_NOP,      COND_NO_POP,   UPC_PUSH};
			UPC_O2:   return '{ACT_POP_EMIT, COND_ALWAYS,   UPC_O0};
			// shared push for function, operator and left paren
			UPC_PUSH: return '{ACT_PUSH,     COND_ALWAYS,   UPC_DONE};
			// right paren: pop operators, drop the paren, pop a function
			UPC_R0:   return '{ACT_READ,     COND_EMPTY,    UPC_RERR};
			UPC_R1:   return '{ACT_NOP,      COND_NOT_OPER, UPC_R3};
			UPC_R2:   return '{ACT_POP_EMIT, COND_ALWAYS,   UPC_R0};
			UPC_R3:   return '{ACT_NOP,      COND_NOT_LPAR, UPC_RERR};
			UPC_R4:   return '{ACT_POP_DROP, COND_NEVER,    UPC_IDLE};
			UPC_R5:   return '{ACT_READ,     COND_EMPTY,    UPC_DONE};
			UPC_R6:   return '{ACT_NOP,      COND_NOT_FUNC, UPC_DONE};
			UPC_R7:   return '{ACT_POP_EMIT, COND_ALWAYS,   UPC_DONE};
			UPC_RERR: return '{ACT_ERR_RPAR, COND_ALWAYS,   UPC_DONE};
			// end of expression: flush the whole stack
			UPC_E0:   return '{ACT_READ,     COND_EMPTY,    UPC_DONE};
			UPC_E1:   return '{ACT_POP_EMIT, COND_ALWAYS,   UPC_E0};
			UPC_DONE: return '{ACT_NOP,      COND_DONE,     UPC_IDLE};
			default:  return '{ACT_NOP,      COND_ALWAYS,   UPC_IDLE};
		endcase
	endfunction

	// Entry point of the microprogram for each token code
	function automatic upc_t dispatch(input logic [2:0] op);
		case (op)
			TOK_OPERAND: return UPC_OPND;
			TOK_FUNC:    return UPC_PUSH;
			TOK_OPER:    return UPC_O0;
			TOK_LPAR:    return UPC_PUSH;
			TOK_RPAR:    return UPC_R0;
			TOK_END:     return UPC_E0;
			default:     return UPC_DONE;
		endcase
	endfunction

endpackage

// ===== rtl/core/infix_to_postfix_converter.sv =====
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard converter: takes classified tokens, keeps an operator stack
// and sends tokens out in postfix order, flagging paren and overflow errors.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Handshake            Payload
// input    in         in_valid / in_stall  op, token_id, precedence, left_assoc
// result   out        out_valid / out_stall out_token_id, out_kind, error, last
//
// A microcoded sequencer runs one short program per token. A pop in the end
// flush is a registered read of the stack memory followed by the pop; a pop
// for an operator or a right paren adds a step between the two that tests
// the top. Each token also has an accept step and a finish step.
// Reset clears the step counter, stack count and valid flags; the stack
// memory is not cleared and needs no sweep.
// A stalled result channel, with a result already held back, holds the
// sequencer at its next emitting or finishing step.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter import i2p_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        op,
	input  logic [ID_W-1:0]   token_id,
	input  logic [PREC_W-1:0] precedence,
	input  logic              left_assoc,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [ID_W-1:0]   out_token_id,
	output logic [1:0]        out_kind,
	output logic [1:0]        error,
	output logic              last
);

	// Sequencer and stack control state
	upc_t             upc_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pend_valid_q;
	logic             out_valid_q;

	// Current token
	logic [2:0]        op_q;
	logic [ID_W-1:0]   id_q;
	logic [PREC_W-1:0] prec_q;
	logic              la_q;

	// Stack memory and its registered top
	stk_entry_t stack_mem [STACK_DEPTH];
	stk_entry_t top_q;

	// Held-back result and output register
	logic [ID_W-1:0] pend_id_q;
	logic [1:0]      pend_kind_q;
	logic [1:0]      pend_err_q;
	logic [ID_W-1:0] out_id_q;
	logic [1:0]      out_kind_q;
	logic [1:0]      out_err_q;
	logic            out_last_q;

	// Combinational control
	ucw_t             ucw;
	logic             in_accept;
	logic             out_free;
	logic             stack_full;
	logic             cond_hit;
	logic             emit_req;
	logic [ID_W-1:0]  emit_id;
	logic [1:0]       emit_kind;
	logic [1:0]       emit_err;
	logic             rd_en;
	logic             push_req;
	logic             pop_req;
	logic             step_go;
	logic             pend_load;
	logic             out_load;
	logic             pend_clear;
	upc_t             upc_next;
	stk_entry_t       push_entry;
	logic [CNT_W-1:0] cnt_m1;

	assign in_stall   = (upc_q != UPC_IDLE);
	assign in_accept  = in_valid && !in_stall;
	assign out_free   = !out_valid_q || !out_stall;
	assign stack_full = (cnt_q == CNT_W'(STACK_DEPTH));
	assign cnt_m1     = cnt_q - CNT_W'(1);

	// Decode the control word, evaluate the jump and gate the datapath
	always_comb begin
		ucw        = ucode(upc_q);
		emit_req   = 1'b0;
		emit_id    = id_q;
		emit_kind  = K_OPERAND;
		emit_err   = ERR_NONE;
		rd_en      = 1'b0;
		push_req   = 1'b0;
		pop_req    = 1'b0;
		cond_hit   = 1'b0;
		push_entry = '{id: id_q, prec: '0, kind: K_LPAR};

		case (op_q)
			TOK_FUNC: push_entry.kind = K_FUNC;
			TOK_OPER: begin
				push_entry.kind = K_OPER;
				push_entry.prec = prec_q;
			end
			default: push_entry.kind = K_LPAR;
		endcase

		case (ucw.act)
			ACT_READ: rd_en = 1'b1;
			ACT_EMIT_IN: emit_req = 1'b1;
			ACT_PUSH: begin
				if (stack_full) begin
					emit_req = 1'b1;
					emit_err = ERR_OVERFLOW;
					emit_kind = (push_entry.kind == K_LPAR) ? K_OPERAND : push_entry.kind;
				end else begin
					push_req = 1'b1;
				end
			end
			ACT_POP_EMIT: begin
				pop_req  = 1'b1;
				emit_req = 1'b1;
				emit_id  = top_q.id;
				if (top_q.kind == K_LPAR) begin
					emit_err = ERR_LPAR;
				end else begin
					emit_kind = top_q.kind;
				end
			end
			ACT_POP_DROP: pop_req = 1'b1;
			ACT_ERR_RPAR: begin
				emit_req = 1'b1;
				emit_err = ERR_RPAR;
			end
			default: ;
		endcase

		case (ucw.cond)
			COND_ALWAYS:   cond_hit = 1'b1;
			COND_EMPTY:    cond_hit = (cnt_q == '0);
			COND_NO_POP:   cond_hit = (top_q.kind != K_OPER) ||
			                          !((top_q.prec > prec_q) ||
			                            ((top_q.prec == prec_q) && la_q));
			COND_NOT_OPER: cond_hit = (top_q.kind != K_OPER);
			COND_NOT_LPAR: cond_hit = (top_q.kind != K_LPAR);
			COND_NOT_FUNC: cond_hit = (top_q.kind != K_FUNC);
			COND_DONE:     cond_hit = 1'b1;
			default:       cond_hit = 1'b0;
		endcase

		// Hold on an emit or a finish that needs the output register while it is busy
		step_go = (ucw.act != ACT_IDLE) &&
		          !(pend_valid_q && !out_free && (emit_req || (ucw.cond == COND_DONE)));

		pend_load  = step_go && emit_req;
		pend_clear = step_go && (ucw.cond == COND_DONE) && pend_valid_q;
		out_load   = (pend_load && pend_valid_q) || pend_clear;

		if (ucw.act == ACT_IDLE) begin
			upc_next = in_accept ? dispatch(op) : upc_q;
		end else if (step_go) begin
			upc_next = cond_hit ? ucw.target : upc_q + UPC_W'(1);
		end else begin
			upc_next = upc_q;
		end
	end

	// Advance the sequencer, stack count and valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q        <= UPC_IDLE;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			upc_q <= upc_next;
			if (step_go && push_req) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (step_go && pop_req) begin
				cnt_q <= cnt_m1;
			end
			if (pend_load) begin
				pend_valid_q <= 1'b1;
			end else if (pend_clear) begin
				pend_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Capture the token on acceptance
	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q   <= op;
			id_q   <= token_id;
			prec_q <= precedence;
			la_q   <= left_assoc;
		end
	end

	// Write the stack on a push, read its top on a read step
	always_ff @(posedge clk) begin
		if (step_go && push_req) begin
			stack_mem[cnt_q[ADDR_W-1:0]] <= push_entry;
		end
		if (rd_en) begin
			top_q <= stack_mem[cnt_m1[ADDR_W-1:0]];
		end
	end

	// Hold one result back so the last one of a transaction can be marked
	always_ff @(posedge clk) begin
		if (pend_load) begin
			pend_id_q   <= emit_id;
			pend_kind_q <= emit_kind;
			pend_err_q  <= emit_err;
		end
		if (out_load) begin
			out_id_q   <= pend_id_q;
			out_kind_q <= pend_kind_q;
			out_err_q  <= pend_err_q;
			out_last_q <= pend_clear;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_token_id = out_id_q;
	assign out_kind     = out_kind_q;
	assign error        = out_err_q;
	assign last         = out_last_q;

`ifndef NO_ASSERTIONS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(upc_q == UPC_IDLE) |-> !pend_valid_q)
		else $error("held result left behind at end of token");

	a_out_from_pend: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(pend_valid_q))
		else $error("result loaded without a held result");
`endif

endmodule

// ===== tb/sv/i2p_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_tb_pkg
// Postfix predictor and result checker for the infix to postfix converter:
// mirrors the operator stack, queues the tokens each input should produce
// and compares every result transaction with the oldest one queued.
// ----------------------------------------------------------------------------
package i2p_tb_pkg;
	import i2p_pkg::*;

	typedef struct {
		logic [ID_W-1:0] id;
		kind_t           kind;
		err_t            err;
		logic            last;
	} postfix_tok_t;

	class postfix_scoreboard;
		logic [ID_W-1:0]   stk_id   [STACK_DEPTH];
		logic [PREC_W-1:0] stk_prec [STACK_DEPTH];
		kind_t             stk_kind [STACK_DEPTH];
		int                depth;
		postfix_tok_t      expected_postfix[$];
		int                mismatches;

		function new();
			depth = 0;
			mismatches = 0;
		endfunction

		function int pending();
			return expected_postfix.size();
		endfunction

		// Queue one expected output token
		function void emit(logic [ID_W-1:0] id, kind_t kind, err_t err);
			postfix_tok_t t;
			t.id = id;
			t.kind = kind;
			t.err = err;
			t.last = 1'b0;
			expected_postfix.insert(expected_postfix.size(), t);
		endfunction

		// Push, or report an overflow and drop the token
		function void push_entry(logic [ID_W-1:0] id, logic [PREC_W-1:0] prec, kind_t kind);
			if (depth >= STACK_DEPTH) begin
				emit(id, (kind == K_LPAR) ? K_OPERAND : kind, ERR_OVERFLOW);
			end else begin
				stk_id[depth] = id;
				stk_prec[depth] = prec;
				stk_kind[depth] = kind;
				depth++;
			end
		endfunction

		function void pop_emit();
			depth--;
			emit(stk_id[depth], stk_kind[depth], ERR_NONE);
		endfunction

		// Work out the postfix tokens released by one accepted input
		function void note_token(logic [2:0] op, logic [ID_W-1:0] id,
				logic [PREC_W-1:0] prec, logic la);
			int first;
			postfix_tok_t t;
			first = expected_postfix.size();
			case (op)
				TOK_OPERAND: emit(id, K_OPERAND, ERR_NONE);
				TOK_FUNC: push_entry(id, '0, K_FUNC);
				TOK_OPER: begin
					// pop while the top binds tighter
					while (depth > 0 && stk_kind[depth-1] == K_OPER &&
							(stk_prec[depth-1] > prec || (stk_prec[depth-1] == prec && la)))
						pop_emit();
					push_entry(id, prec, K_OPER);
				end
				TOK_LPAR: push_entry(id, '0, K_LPAR);
				TOK_RPAR: begin
					while (depth > 0 && stk_kind[depth-1] == K_OPER)
						pop_emit();
					if (depth > 0 && stk_kind[depth-1] == K_LPAR) begin
						depth--;
						if (depth > 0 && stk_kind[depth-1] == K_FUNC)
							pop_emit();
					end else begin
						emit(id, K_OPERAND, ERR_RPAR);
					end
				end
				TOK_END: begin
					// flush, flagging every open paren
					while (depth > 0) begin
						if (stk_kind[depth-1] == K_LPAR) begin
							depth--;
							emit(stk_id[depth], K_OPERAND, ERR_LPAR);
						end else begin
							pop_emit();
						end
					end
				end
				default: ;
			endcase
			// mark the final token of this input
			if (expected_postfix.size() > first) begin
				t = expected_postfix[expected_postfix.size() - 1];
				t.last = 1'b1;
				expected_postfix[expected_postfix.size() - 1] = t;
			end
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("%s", msg);
		endfunction

		// Compare one accepted result with the oldest expectation
		function void check_token(logic [ID_W-1:0] id, logic [1:0] kind, logic [1:0] err,
				logic last);
			postfix_tok_t want;
			if (expected_postfix.size() == 0) begin
				flag($sformatf("unexpected result: id %h kind %0d error %0d last %0d",
					id, kind, err, last));
			end else begin
				want = expected_postfix.pop_front();
				if (id !== want.id || kind !== want.kind || err !== want.err ||
						last !== want.last)
					flag($sformatf({"mismatch: expected id %h kind %0d error %0d last %0d,",
						" got id %h kind %0d error %0d last %0d"},
						want.id, want.kind, want.err, want.last, id, kind, err, last));
			end
		endfunction
	endclass

endpackage

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the infix to postfix converter. Directed tokens cover the
// operator rules, paren errors and stack overflow; random well-formed
// expressions mixed with stray tokens follow, under varying idle rates on
// both channels and one long result stall.
// ----------------------------------------------------------------------------
module tb;
	import i2p_pkg::*;
	import i2p_tb_pkg::*;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [2:0]        op;
	logic [ID_W-1:0]   token_id;
	logic [PREC_W-1:0] precedence;
	logic              left_assoc;
	logic              out_valid;
	logic              out_stall;
	logic [ID_W-1:0]   out_token_id;
	logic [1:0]        out_kind;
	logic [1:0]        error;
	logic              last;

	postfix_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_left = 0;
	int tokens_sent = 0;

	infix_to_postfix_converter dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .token_id(token_id), .precedence(precedence), .left_assoc(left_assoc),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_token_id(out_token_id), .out_kind(out_kind), .error(error), .last(last)
	);

	always #4 clk = ~clk;

	// Offer one token and wait until the transaction completes
	task automatic send_token(input logic [2:0] t_op, input logic [ID_W-1:0] t_id,
			input logic [PREC_W-1:0] t_prec, input logic t_la);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op <= t_op;
		token_id <= t_id;
		precedence <= t_prec;
		left_assoc <= t_la;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_token(t_op, t_id, t_prec, t_la);
		tokens_sent++;
		@(negedge clk);
	endtask

	task automatic send_rand(input logic [2:0] t_op);
		send_token(t_op, ID_W'($urandom), PREC_W'($urandom_range(15)), 1'($urandom_range(1)));
	endtask

	// Drive one well-formed expression with random content
	task automatic send_expression(input int max_nest, input int target);
		int  nest;
		int  len;
		int  r;
		bit  want_operand;
		bit  done;
		nest = 0;
		len = 0;
		want_operand = 1'b1;
		done = 1'b0;
		while (!done) begin
			r = $urandom_range(99);
			len++;
			if (want_operand) begin
				if (nest < max_nest && r < 12) begin
					send_rand(TOK_FUNC);
					send_rand(TOK_LPAR);
					nest++;
				end else if (nest < max_nest && r < 30) begin
					send_rand(TOK_LPAR);
					nest++;
				end else begin
					send_rand(TOK_OPERAND);
					want_operand = 1'b0;
				end
			end else if (nest > 0 && (r < 25 || len > target)) begin
				send_rand(TOK_RPAR);
				nest--;
			end else if (len > target) begin
				send_rand(TOK_END);
				done = 1'b1;
			end else begin
				send_rand(TOK_OPER);
				want_operand = 1'b1;
			end
		end
	endtask

	// Mostly expressions, some stray tokens and a few deep ones
	task automatic run_random(input int count);
		int start;
		int r;
		start = tokens_sent;
		while (tokens_sent - start < count) begin
			r = $urandom_range(99);
			if (r < 12)
				repeat ($urandom_range(1, 3)) send_rand(3'($urandom_range(7)));
			else if (r < 15)
				send_expression(14, 40);
			else
				send_expression(4, $urandom_range(2, 12));
		end
	endtask

	// Result side: stall at random or for a held stretch, check on accept
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				sb.check_token(out_token_id, out_kind, error, last);
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// Stimulus
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = TOK_OPERAND;
		token_id = '0;
		precedence = '0;
		left_assoc = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_idle_pct = 27;
		recv_idle_pct = 65;

		// extremes and the operator rules
		send_token(TOK_OPERAND, 16'h0000, 4'h0, 1'b0);
		send_token(TOK_OPERAND, 16'hffff, 4'hf, 1'b1);
		send_rand(TOK_FUNC);
		send_rand(TOK_LPAR);
		send_rand(TOK_OPERAND);
		send_token(TOK_OPER, ID_W'($urandom), 4'h0, 1'b1);
		send_rand(TOK_OPERAND);
		send_token(TOK_OPER, ID_W'($urandom), 4'h0, 1'b1);
		send_rand(TOK_OPERAND);
		send_token(TOK_OPER, ID_W'($urandom), 4'hf, 1'b0);
		send_rand(TOK_OPERAND);
		send_token(TOK_OPER, ID_W'($urandom), 4'hf, 1'b0);
		send_rand(TOK_OPERAND);
		send_rand(TOK_RPAR);
		// unmatched right paren on an empty stack and under a function
		send_token(TOK_OPER, ID_W'($urandom), 4'h7, 1'b0);
		send_rand(TOK_RPAR);
		send_rand(TOK_FUNC);
		send_rand(TOK_RPAR);
		// unused codes, then an open paren left at the end
		send_rand(TOK_LPAR);
		send_rand(TOK_OPERAND);
		send_rand(3'd6);
		send_rand(3'd7);
		send_rand(TOK_END);
		send_rand(TOK_RPAR);
		send_rand(TOK_END);

		// fill the stack, overflow with each kind, then empty it in one go
		repeat (STACK_DEPTH) send_token(TOK_OPER, ID_W'($urandom), 4'h5, 1'b0);
		send_rand(TOK_FUNC);
		send_rand(TOK_LPAR);
		send_token(TOK_OPER, ID_W'($urandom), 4'h5, 1'b0);
		send_rand(TOK_RPAR);
		repeat (STACK_DEPTH + 1) send_rand(TOK_LPAR);
		send_rand(TOK_END);

		run_random(70);

		send_idle_pct = 65;
		recv_idle_pct = 27;
		run_random(70);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		// hold the result side off while tokens keep coming
		hold_left = 300;
		send_expression(4, 30);
		run_random(70);
		in_valid <= 1'b0;

		// drain, then allow for any late result
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("PASS infix_to_postfix_converter");
		end else begin
			$display("FAIL infix_to_postfix_converter");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#4_000_000;
		$display("FAIL infix_to_postfix_converter");
		$finish;
	end

endmodule

// ===== infix_to_postfix_converter.f =====
rtl/core/i2p_pkg.sv
rtl/core/infix_to_postfix_converter.sv
tb/sv/i2p_tb_pkg.sv
tb/sv/tb.sv
